// ===== src/touch_dejitter_lowpass_assert.svh =====
// Assertion macros shared by the touch dejitter filter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TOUCH_DEJITTER_LOWPASS_ASSERT_SVH
`define TOUCH_DEJITTER_LOWPASS_ASSERT_SVH

// Check a property on a given clock, disabled while the given low reset is active.
`define TDL_ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the standard clk_i / rst_ni pair of the enclosing module.
`define TDL_ASSERT(label, prop, msg) \
  `TDL_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

// ===== src/tdl_pkg.sv =====
// Shared types and constants for the touch dejitter low-pass filter.
// Used by tdl_lane, tdl_slot_store and touch_dejitter_lowpass.
package tdl_pkg;

  // Field widths
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned PRES_W     = 16;
  localparam int unsigned FACTOR_W   = 9;
  localparam int unsigned DZ_W       = 8;

  // Stream packing: tdata = {pressure, y, x}, tuser = {valid, slot}
  localparam int unsigned TDATA_W    = 2 * COORD_W + PRES_W;
  localparam int unsigned TUSER_W    = SLOT_W + 1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = FACTOR_W;

  // Register reset values and limits
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 9'd102;
  localparam logic [FACTOR_W-1:0] FACTOR_MAX   = 9'd256;
  localparam logic [DZ_W-1:0]     DZ_RESET     = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FACTOR_Q8 = 2'd0,
    REG_DEAD_ZONE = 2'd1
  } cfg_reg_e;

  // Per-slot state update issued by the filter stage
  typedef struct packed {
    logic               coord_we;
    logic               pen_we;
    logic               pen_val;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } tdl_wr_t;

endpackage

// ===== src/tdl_lane.sv =====
// One axis of the dejitter filter: dead zone, factor scaling, step toward input.
// Depends on tdl_pkg for field widths.
module tdl_lane (
  input  logic signed [tdl_pkg::COORD_W-1:0]  prev_i,
  input  logic signed [tdl_pkg::COORD_W-1:0]  cur_i,
  input  logic        [tdl_pkg::FACTOR_W-1:0] factor_i,
  input  logic        [tdl_pkg::DZ_W-1:0]     dead_zone_i,
  output logic signed [tdl_pkg::COORD_W-1:0]  res_o
);
  import tdl_pkg::*;

  localparam int unsigned PROD_W = COORD_W + FACTOR_W;

  logic signed [COORD_W:0]   diff;
  logic        [COORD_W:0]   diff_neg;
  logic                      neg;
  logic        [COORD_W-1:0] mag;
  logic                      in_dead;
  logic        [PROD_W-1:0]  prod;
  logic        [COORD_W-1:0] step;
  logic signed [COORD_W:0]   prev_ext;
  logic signed [COORD_W:0]   step_ext;
  logic signed [COORD_W:0]   sum;

  // Signed difference and its magnitude
  assign diff     = {cur_i[COORD_W-1], cur_i} - {prev_i[COORD_W-1], prev_i};
  assign diff_neg = -diff;
  assign neg      = diff[COORD_W];
  assign mag      = neg ? diff_neg[COORD_W-1:0] : diff[COORD_W-1:0];

  // Drop changes inside the dead zone
  assign in_dead = (mag <= {{(COORD_W-DZ_W){1'b0}}, dead_zone_i});

  // Scale the magnitude by factor/256, truncating toward zero
  assign prod = PROD_W'(mag) * PROD_W'(factor_i);
  assign step = prod[COORD_W+7:8];

  // Move the stored value toward the input; the sum stays between the two
  assign prev_ext = {prev_i[COORD_W-1], prev_i};
  assign step_ext = {1'b0, step};
  assign sum      = neg ? (prev_ext - step_ext) : (prev_ext + step_ext);

  assign res_o = in_dead ? prev_i : sum[COORD_W-1:0];

endmodule

// ===== src/tdl_slot_store.sv =====
// Per-slot state of the dejitter filter: pen-up flags and last x/y memory,
// with registered read and forwarding of the latest write. Depends on tdl_pkg.
module tdl_slot_store #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               rd_en_i,
  input  logic        [tdl_pkg::SLOT_W-1:0]  rd_slot_i,
  input  logic        [tdl_pkg::SLOT_W-1:0]  cur_slot_i,
  input  tdl_pkg::tdl_wr_t                   wr_i,
  output logic                               pen_up_o,
  output logic signed [tdl_pkg::COORD_W-1:0] prev_x_o,
  output logic signed [tdl_pkg::COORD_W-1:0] prev_y_o
);
  import tdl_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  logic [2*COORD_W-1:0] mem_q [SLOTS];
  logic [2*COORD_W-1:0] rd_q;
  logic [SLOTS-1:0]     pen_q;
  logic                 fwd_valid_q;
  logic [SLOT_W-1:0]    fwd_slot_q;
  logic [2*COORD_W-1:0] fwd_data_q;

  logic [EXT_W-1:0]     rd_ext;
  logic [EXT_W-1:0]     wr_ext;
  logic [EXT_W-1:0]     cur_ext;
  logic [IDX_W-1:0]     rd_idx;
  logic [IDX_W-1:0]     wr_idx;
  logic [IDX_W-1:0]     cur_idx;
  logic                 fwd_hit;
  logic [2*COORD_W-1:0] prev;

  // Map the slot field onto the storage index
  assign rd_ext  = EXT_W'(rd_slot_i);
  assign wr_ext  = EXT_W'(wr_i.slot);
  assign cur_ext = EXT_W'(cur_slot_i);
  assign rd_idx  = rd_ext[IDX_W-1:0];
  assign wr_idx  = wr_ext[IDX_W-1:0];
  assign cur_idx = cur_ext[IDX_W-1:0];

  // Coordinate memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.coord_we) begin
      mem_q[wr_idx] <= {wr_i.y, wr_i.x};
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_idx];
    end
  end

  // Pen-up flags: every slot starts lifted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q <= '1;
    end else if (wr_i.pen_we) begin
      pen_q[wr_idx] <= wr_i.pen_val;
    end
  end

  // Hold the latest coordinate write to cover a read taken on the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (wr_i.coord_we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.coord_we) begin
      fwd_slot_q <= wr_i.slot;
      fwd_data_q <= {wr_i.y, wr_i.x};
    end
  end

  // Select the freshest stored position for the item in the filter stage
  assign fwd_hit  = fwd_valid_q && (fwd_slot_q == cur_slot_i);
  assign prev     = fwd_hit ? fwd_data_q : rd_q;
  assign prev_x_o = prev[COORD_W-1:0];
  assign prev_y_o = prev[2*COORD_W-1:COORD_W];
  assign pen_up_o = pen_q[cur_idx];

endmodule

// ===== src/touch_dejitter_lowpass.sv =====
// Touch dejitter low-pass filter: stream in, per-slot state, x/y lanes, stream out.
// Depends on tdl_pkg, tdl_lane, tdl_slot_store and touch_dejitter_lowpass_assert.svh.
//
// Usage:
//   s_axis carries one touch sample per beat: tdata = {pressure, y, x} and
//   tuser = {valid, slot}. m_axis returns one beat per input beat in the same
//   packing, with x and y filtered or passed through. The cfg channel writes
//   factor_q8 (index 0) and dead_zone (index 1); cfg_ready_o is always high,
//   and writes are meant to land only while no beat is in flight.
//   An accepted beat is held in the filter stage register, then in the output
//   register, and then presented on m_axis. Throughput: one beat per cycle while
//   the receiver does not stall, set by the read-modify-write of a slot's stored
//   position, closed by a forwarding register on the slot memory.
//   Reset clears both pipeline valids, sets every slot to pen-up and loads
//   factor_q8 = 102 and dead_zone = 2. When the receiver stalls, the output
//   beat holds; the filter stage fills behind it and s_axis_tready drops
//   until the output drains.
`include "touch_dejitter_lowpass_assert.svh"
module touch_dejitter_lowpass #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tdl_pkg::TDATA_W-1:0]      s_axis_tdata,  // x_in, y_in, pressure_in
  input  logic [tdl_pkg::TUSER_W-1:0]      s_axis_tuser,  // slot, valid_req
  // Output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tdl_pkg::TDATA_W-1:0]      m_axis_tdata,  // x_out, y_out, pressure_out
  output logic [tdl_pkg::TUSER_W-1:0]      m_axis_tuser,  // slot_out, valid_out
  // Configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tdl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tdl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import tdl_pkg::*;

  // Configuration registers
  logic [FACTOR_W-1:0] factor_q;
  logic [DZ_W-1:0]     dz_q;

  // Filter stage
  logic                      a_valid_q;
  logic [SLOT_W-1:0]         a_slot_q;
  logic                      a_vreq_q;
  logic signed [COORD_W-1:0] a_x_q;
  logic signed [COORD_W-1:0] a_y_q;
  logic [PRES_W-1:0]         a_p_q;

  // Output register
  logic                      out_valid_q;
  logic [SLOT_W-1:0]         out_slot_q;
  logic                      out_vreq_q;
  logic [COORD_W-1:0]        out_x_q;
  logic [COORD_W-1:0]        out_y_q;
  logic [PRES_W-1:0]         out_p_q;

  logic                      s_acc;
  logic                      a_adv;
  logic                      in_range;
  logic                      active;
  logic                      pres_zero;
  logic                      pen_up;
  logic                      smooth;
  logic signed [COORD_W-1:0] prev_x;
  logic signed [COORD_W-1:0] prev_y;
  logic signed [COORD_W-1:0] lane_x;
  logic signed [COORD_W-1:0] lane_y;
  logic [COORD_W-1:0]        res_x;
  logic [COORD_W-1:0]        res_y;
  tdl_wr_t                   wr;
  logic                      chk_smooth;
  logic                      x_between;
  logic                      y_between;

  // Configuration write channel
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_RESET;
      dz_q     <= DZ_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FACTOR_Q8: begin
          // Clamp above 256 so the lane never scales past the input
          factor_q <= (cfg_data_i > FACTOR_MAX) ? FACTOR_MAX : cfg_data_i;
        end
        REG_DEAD_ZONE: begin
          dz_q <= cfg_data_i[DZ_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake: filter stage advances into the output register when it is free
  assign a_adv         = a_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !a_valid_q || a_adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_acc) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      a_slot_q <= s_axis_tuser[SLOT_W-1:0];
      a_vreq_q <= s_axis_tuser[SLOT_W];
      a_x_q    <= s_axis_tdata[COORD_W-1:0];
      a_y_q    <= s_axis_tdata[2*COORD_W-1:COORD_W];
      a_p_q    <= s_axis_tdata[TDATA_W-1:2*COORD_W];
    end
  end

  // Slot state, read when a beat is accepted
  tdl_slot_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (s_acc),
    .rd_slot_i  (s_axis_tuser[SLOT_W-1:0]),
    .cur_slot_i (a_slot_q),
    .wr_i       (wr),
    .pen_up_o   (pen_up),
    .prev_x_o   (prev_x),
    .prev_y_o   (prev_y)
  );

  // One lane per axis
  tdl_lane u_lane_x (
    .prev_i      (prev_x),
    .cur_i       (a_x_q),
    .factor_i    (factor_q),
    .dead_zone_i (dz_q),
    .res_o       (lane_x)
  );

  tdl_lane u_lane_y (
    .prev_i      (prev_y),
    .cur_i       (a_y_q),
    .factor_i    (factor_q),
    .dead_zone_i (dz_q),
    .res_o       (lane_y)
  );

  // Merge: decide pass-through, first touch or smoothing, and the state update
  assign in_range  = ({4'd0, a_slot_q} < 8'(SLOTS));
  assign active    = a_vreq_q && in_range;
  assign pres_zero = (a_p_q == '0);
  assign smooth    = active && !pres_zero && !pen_up;

  always_comb begin
    wr.coord_we = a_adv && active && !pres_zero;
    wr.pen_we   = a_adv && active && (pres_zero || pen_up);
    wr.pen_val  = pres_zero;
    wr.slot     = a_slot_q;
    res_x       = smooth ? lane_x : a_x_q;
    res_y       = smooth ? lane_y : a_y_q;
    wr.x        = res_x;
    wr.y        = res_y;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (a_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      out_slot_q <= a_slot_q;
      out_vreq_q <= a_vreq_q;
      out_x_q    <= res_x;
      out_y_q    <= res_y;
      out_p_q    <= a_p_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_p_q, out_y_q, out_x_q};
  assign m_axis_tuser  = {out_vreq_q, out_slot_q};

  // Checks
  assign chk_smooth = a_adv && smooth;
  assign x_between  = (lane_x >= prev_x && lane_x <= a_x_q) ||
                      (lane_x <= prev_x && lane_x >= a_x_q);
  assign y_between  = (lane_y >= prev_y && lane_y <= a_y_q) ||
                      (lane_y <= prev_y && lane_y >= a_y_q);

  `TDL_ASSERT(a_x_between, chk_smooth |-> x_between, "x result not between stored and input")
  `TDL_ASSERT(a_y_between, chk_smooth |-> y_between, "y result not between stored and input")
  `TDL_ASSERT(a_adv_shows, a_adv |=> m_axis_tvalid, "advanced beat not presented on output")

endmodule

// ===== tb/sv/touch_dejitter_checker.sv =====
// Stream checker for the touch dejitter filter: predicts each output beat and compares.
// Watches the input, output and config channels of touch_dejitter_lowpass; uses tdl_pkg.
module touch_dejitter_checker #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [tdl_pkg::TDATA_W-1:0]    s_axis_tdata,   // x_in, y_in, pressure_in
  input  logic [tdl_pkg::TUSER_W-1:0]    s_axis_tuser,   // slot, valid_req
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [tdl_pkg::TDATA_W-1:0]    m_axis_tdata,   // x_out, y_out, pressure_out
  input  logic [tdl_pkg::TUSER_W-1:0]    m_axis_tuser,   // slot_out, valid_out
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_o,
  input  logic [tdl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tdl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import tdl_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PRES_W-1:0]  pressure;
  } touch_beat_t;

  // Shadow of the block's registers and per-slot state
  logic [FACTOR_W-1:0] factor_q8;
  logic [DZ_W-1:0]     dead_zone;
  logic [SLOTS-1:0]    pen_up;
  logic [COORD_W-1:0]  last_x [SLOTS];
  logic [COORD_W-1:0]  last_y [SLOTS];

  touch_beat_t filtered_q[$];
  int          fail_count;

  function automatic touch_beat_t unpack_beat(input logic [TDATA_W-1:0] data,
                                              input logic [TUSER_W-1:0] user);
    touch_beat_t b;
    b.x        = data[COORD_W-1:0];
    b.y        = data[2*COORD_W-1:COORD_W];
    b.pressure = data[2*COORD_W+PRES_W-1:2*COORD_W];
    b.slot     = user[SLOT_W-1:0];
    b.valid    = user[SLOT_W];
    return b;
  endfunction

  // Move one axis toward the new sample, ignoring changes inside the dead zone
  function automatic logic [COORD_W-1:0] dejitter_axis(input logic [COORD_W-1:0] prev,
                                                       input logic [COORD_W-1:0] cur);
    int diff;
    int mag;
    int gain;
    int step;
    diff = int'($signed(cur)) - int'($signed(prev));
    mag  = (diff < 0) ? -diff : diff;
    gain = (factor_q8 > FACTOR_MAX) ? int'(FACTOR_MAX) : int'(factor_q8);
    if (mag <= int'(dead_zone)) return prev;
    step = (mag * gain) >>> 8;
    if (diff < 0) return COORD_W'(int'($signed(prev)) - step);
    return COORD_W'(int'($signed(prev)) + step);
  endfunction

  // Compute the output beat for one input beat and advance the slot state
  function automatic touch_beat_t dejitter_touch(input touch_beat_t in);
    touch_beat_t res;
    res = in;
    if (in.valid && in.slot < SLOTS) begin
      if (in.pressure == '0) begin
        pen_up[in.slot] = 1'b1;
      end else if (pen_up[in.slot]) begin
        pen_up[in.slot] = 1'b0;
        last_x[in.slot] = in.x;
        last_y[in.slot] = in.y;
      end else begin
        res.x = dejitter_axis(last_x[in.slot], in.x);
        res.y = dejitter_axis(last_y[in.slot], in.y);
        last_x[in.slot] = res.x;
        last_y[in.slot] = res.y;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    touch_beat_t want;
    touch_beat_t got;
    if (!rst_ni) begin
      factor_q8  = FACTOR_RESET;
      dead_zone  = DZ_RESET;
      pen_up     = '1;
      for (int i = 0; i < SLOTS; i++) begin
        last_x[i] = '0;
        last_y[i] = '0;
      end
      filtered_q.delete();
      fail_count = 0;
    end else begin
      // Compare the output beat first; it always belongs to an earlier input
      if (m_axis_tvalid && m_axis_tready) begin
        got = unpack_beat(m_axis_tdata, m_axis_tuser);
        if (filtered_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected output beat: slot=%0d valid=%0b x=%0d y=%0d p=%0d",
                     $time, got.slot, got.valid, $signed(got.x), $signed(got.y),
                     got.pressure);
        end else begin
          want = filtered_q.pop_front();
          if (want.slot != got.slot || want.valid != got.valid || want.x != got.x ||
              want.y != got.y || want.pressure != got.pressure) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"[%0t] mismatch: expected slot=%0d valid=%0b x=%0d y=%0d p=%0d,",
                        " got slot=%0d valid=%0b x=%0d y=%0d p=%0d"},
                       $time, want.slot, want.valid, $signed(want.x), $signed(want.y),
                       want.pressure, got.slot, got.valid, $signed(got.x),
                       $signed(got.y), got.pressure);
          end
        end
      end
      // Queue the prediction for an accepted input beat
      if (s_axis_tvalid && s_axis_tready)
        filtered_q.push_back(dejitter_touch(unpack_beat(s_axis_tdata, s_axis_tuser)));
      // Track register writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_FACTOR_Q8: begin
            factor_q8 = cfg_data_i[FACTOR_W-1:0];
          end
          REG_DEAD_ZONE: begin
            dead_zone = cfg_data_i[DZ_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= filtered_q.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the touch dejitter filter testbench: clock, reset, stimulus and verdict.
// Instantiates touch_dejitter_lowpass and touch_dejitter_checker; uses tdl_pkg.
module testbench;
  import tdl_pkg::*;

  localparam int NUM_SLOTS   = 16;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 50;
  localparam int IDLE_LIMIT  = 1000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata;   // x_in, y_in, pressure_in
  logic [TUSER_W-1:0]    s_axis_tuser;   // slot, valid_req
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;   // x_out, y_out, pressure_out
  logic [TUSER_W-1:0]    m_axis_tuser;   // slot_out, valid_out
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_count;
  int pending;
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int idle_cycles   = 0;
  int dz_setting    = int'(DZ_RESET);

  // Raw positions per slot, used only to shape near moves
  int gen_x [NUM_SLOTS];
  int gen_y [NUM_SLOTS];
  bit gen_down [NUM_SLOTS];

  touch_dejitter_lowpass #(
    .SLOTS(NUM_SLOTS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  touch_dejitter_checker #(
    .SLOTS(NUM_SLOTS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stall the output stream at random
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // End the run when no channel moves a beat for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Present one input beat and hold it until accepted
  task automatic send_sample(input logic [SLOT_W-1:0] slot, input logic vld,
                             input int x, input int y, input logic [PRES_W-1:0] p);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {p, COORD_W'(y), COORD_W'(x)};
    s_axis_tuser  = {vld, slot};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic stop_samples();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Wait for every predicted beat, then let the pipeline settle
  task automatic drain();
    @(negedge clk_i);
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Mostly touch strokes with small moves, plus lifts, jumps and invalid beats
  task automatic send_strokes(input int count, input bit pause_midway);
    int sent;
    int r;
    int span;
    int slot;
    int x;
    int y;
    logic [PRES_W-1:0] p;
    sent = 0;
    while (sent < count) begin
      slot = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : $urandom_range(0, 15);
      r    = $urandom_range(0, 99);
      x    = $signed(16'($urandom()));
      y    = $signed(16'($urandom()));
      if (r < 8) begin
        send_sample(SLOT_W'(slot), 1'b0, x, y, 16'($urandom()));
      end else begin
        if (r < 18) begin
          p = '0;
          gen_down[slot] = 1'b0;
        end else begin
          p = 16'($urandom_range(1, 65535));
          if (gen_down[slot] && $urandom_range(0, 9) < 8) begin
            span = dz_setting + 8;
            x = clamp16(gen_x[slot] + $urandom_range(0, 2 * span) - span);
            y = clamp16(gen_y[slot] + $urandom_range(0, 2 * span) - span);
          end
          gen_down[slot] = 1'b1;
          gen_x[slot] = x;
          gen_y[slot] = y;
        end
        send_sample(SLOT_W'(slot), 1'b1, x, y, p);
      end
      sent++;
      // Hold off the sender until the output side has caught up
      if (pause_midway && sent == count / 2) begin
        stop_samples();
        wait (pending == 0);
      end
    end
    stop_samples();
  endtask

  initial begin
    int factor_set;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_FACTOR_Q8;
    cfg_data_i    = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      gen_x[i]    = 0;
      gen_y[i]    = 0;
      gen_down[i] = 1'b0;
    end
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed beats at the reset settings
    send_sample(0, 1'b0, -32768, 32767, 16'hFFFF);   // invalid beat passes through
    send_sample(0, 1'b1, 0, 0, 16'd1);               // first touch stores position
    send_sample(0, 1'b1, 2, -2, 16'd100);            // on the dead-zone edge
    send_sample(0, 1'b1, 3, -3, 16'd100);            // just outside the dead zone
    send_sample(0, 1'b1, 32767, -32768, 16'hFFFF);   // large move
    send_sample(0, 1'b1, -32768, 32767, 16'h8000);   // full-range swing
    send_sample(0, 1'b1, 5, 5, 16'd0);               // pen lift
    send_sample(0, 1'b1, 100, -100, 16'd7);          // touch after lift
    send_sample(0, 1'b1, 101, -99, 16'd7);           // inside dead zone
    send_sample(15, 1'b1, -32768, -32768, 16'hFFFF);
    send_sample(15, 1'b1, 32767, 32767, 16'd1);
    send_sample(15, 1'b0, 0, 0, 16'd0);              // invalid lift keeps the slot down
    send_sample(15, 1'b1, 32767, 32767, 16'd5);
    send_sample(15, 1'b1, -1, 1, 16'h7FFF);
    send_sample(7, 1'b1, 1234, -4321, 16'd0);        // lift on an untouched slot
    send_sample(7, 1'b1, 1, -1, 16'h5555);
    send_sample(7, 1'b1, -20, 20, 16'hAAAA);
    send_sample(8, 1'b1, 0, 0, 16'd0);
    send_sample(8, 1'b0, 12, 34, 16'd56);
    stop_samples();

    // Random strokes under several settings and idling patterns
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin factor_set = 256; dz_setting = 0;   end
        1: begin factor_set = 0;   dz_setting = 255; end
        2: begin factor_set = 511; dz_setting = 3;   end
        3: begin factor_set = 1;   dz_setting = 0;   end
        4: begin factor_set = 128; dz_setting = 1;   end
        5: begin factor_set = $urandom_range(0, 256); dz_setting = $urandom_range(0, 15); end
        6: begin factor_set = 257; dz_setting = 8;   end
        default: begin factor_set = int'(FACTOR_RESET); dz_setting = int'(DZ_RESET); end
      endcase
      write_reg(REG_FACTOR_Q8, CFG_DATA_W'(factor_set));
      write_reg(REG_DEAD_ZONE, CFG_DATA_W'(dz_setting));
      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 82; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 82; end
        default: begin src_idle_pct = 33; sink_stall_pct = 33; end
      endcase
      send_strokes(PHASE_BEATS, phase == 2 || phase == 7);
    end

    // Let the last beats drain, then give the verdict
    @(negedge clk_i);
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
